// ===== hdl/dflm_pkg.sv =====
package dflm_pkg;

    localparam int NUM_CNT  = 9;
    localparam int CNT_W    = 4;
    localparam int VOLT_W   = 13;
    localparam int TEMP_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // counter slots, in priority order
    localparam int IDX_VOLT_INVALID = 0;
    localparam int IDX_TEMP_INVALID = 1;
    localparam int IDX_OVER_VOLT    = 2;
    localparam int IDX_OVER_TEMP    = 3;
    localparam int IDX_UNDER_VOLT   = 4;
    localparam int IDX_VOLT_STUCK   = 5;
    localparam int IDX_TEMP_STUCK   = 6;
    localparam int IDX_LINK         = 7;
    localparam int IDX_CONTACTOR    = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_VOLT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_VOLT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_PERSIST = 3'd4;

    localparam logic [VOLT_W-1:0] RST_OVER_VOLT    = 13'd4200;
    localparam logic [VOLT_W-1:0] RST_UNDER_VOLT   = 13'd2800;
    localparam logic [TEMP_W-1:0] RST_OVER_TEMP    = 8'd60;
    localparam logic [CNT_W-1:0]  RST_PERSIST      = 4'd3;
    localparam logic [CNT_W-1:0]  RST_LINK_PERSIST = 4'd10;

    localparam logic ACT_EVAL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        FC_NONE          = 4'd0,
        FC_VOLT_INVALID  = 4'd1,
        FC_TEMP_INVALID  = 4'd2,
        FC_OVER_VOLT     = 4'd3,
        FC_OVER_TEMP     = 4'd4,
        FC_UNDER_VOLT    = 4'd5,
        FC_VOLT_STUCK    = 4'd6,
        FC_TEMP_STUCK    = 4'd7,
        FC_LINK_TIMEOUT  = 4'd8,
        FC_CONTACTOR     = 4'd9
    } t_fault_code;

    typedef struct packed {
        logic              action;
        logic [VOLT_W-1:0] cell_voltage_mv;
        logic [TEMP_W-1:0] cell_temp_c;
        logic              temp_stuck;
        logic              voltage_stuck;
        logic              message_sent;
        logic              contactor_commanded;
        logic              contactor_sensed;
    } t_in_item;

    typedef struct packed {
        logic [3:0] fault_code;
        logic       fault_active;
        logic       fault_latched;
    } t_out_item;

    typedef struct packed {
        logic [VOLT_W-1:0] over_voltage_limit_mv;
        logic [VOLT_W-1:0] under_voltage_limit_mv;
        logic [TEMP_W-1:0] over_temp_limit_c;
        logic [CNT_W-1:0]  persist_count;
        logic [CNT_W-1:0]  link_persist_count;
    } t_cfg;

endpackage

// ===== hdl/dflm_cfg_regs.sv =====
module dflm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [dflm_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [dflm_pkg::CFG_DATA_W-1:0] i_data,
    output dflm_pkg::t_cfg                  o_cfg
);
    import dflm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_voltage_limit_mv  <= RST_OVER_VOLT;
            r_cfg.under_voltage_limit_mv <= RST_UNDER_VOLT;
            r_cfg.over_temp_limit_c      <= RST_OVER_TEMP;
            r_cfg.persist_count          <= RST_PERSIST;
            r_cfg.link_persist_count     <= RST_LINK_PERSIST;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_OVER_VOLT:    r_cfg.over_voltage_limit_mv  <= i_data[VOLT_W-1:0];
                CFG_UNDER_VOLT:   r_cfg.under_voltage_limit_mv <= i_data[VOLT_W-1:0];
                CFG_OVER_TEMP:    r_cfg.over_temp_limit_c      <= i_data[TEMP_W-1:0];
                CFG_PERSIST:      r_cfg.persist_count          <= i_data[CNT_W-1:0];
                CFG_LINK_PERSIST: r_cfg.link_persist_count     <= i_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/dflm_core.sv =====
module dflm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dflm_pkg::t_cfg      i_cfg,
    input  logic                i_step,
    input  dflm_pkg::t_in_item  i_item,
    output dflm_pkg::t_out_item o_result
);
    import dflm_pkg::*;

    logic [CNT_W-1:0] r_cnt [NUM_CNT];
    logic [CNT_W-1:0] n_cnt [NUM_CNT];
    logic [CNT_W-1:0] w_tick [NUM_CNT];
    logic             r_latch, n_latch;
    t_fault_code      r_code, n_code;
    logic [NUM_CNT-1:0] w_cond;
    logic [NUM_CNT-1:0] w_hit;
    logic [CNT_W-1:0] w_lim, w_link_lim;

    // a limit of zero acts as one
    assign w_lim      = (i_cfg.persist_count == '0) ? CNT_W'(1) : i_cfg.persist_count;
    assign w_link_lim = (i_cfg.link_persist_count == '0) ? CNT_W'(1)
                                                         : i_cfg.link_persist_count;

    always_comb begin
        w_cond[IDX_VOLT_INVALID] = (i_item.cell_voltage_mv == '0);
        w_cond[IDX_TEMP_INVALID] = (i_item.cell_temp_c == '0);
        w_cond[IDX_OVER_VOLT]    = (i_item.cell_voltage_mv > i_cfg.over_voltage_limit_mv);
        w_cond[IDX_OVER_TEMP]    = (i_item.cell_temp_c > i_cfg.over_temp_limit_c);
        w_cond[IDX_UNDER_VOLT]   = (i_item.cell_voltage_mv < i_cfg.under_voltage_limit_mv);
        w_cond[IDX_VOLT_STUCK]   = i_item.voltage_stuck;
        w_cond[IDX_TEMP_STUCK]   = i_item.temp_stuck;
        w_cond[IDX_LINK]         = !i_item.message_sent;
        w_cond[IDX_CONTACTOR]    = (i_item.contactor_commanded != i_item.contactor_sensed);
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_latch = r_latch;
        n_code  = r_code;
        for (int i = 0; i < NUM_CNT; i++) begin
            if (!w_cond[i]) begin
                w_tick[i] = '0;
            end else if (r_cnt[i] == CNT_MAX) begin
                w_tick[i] = CNT_MAX;
            end else begin
                w_tick[i] = r_cnt[i] + CNT_W'(1);
            end
            w_hit[i] = (w_tick[i] >= ((i == IDX_LINK) ? w_link_lim : w_lim));
        end
        if (i_item.action == ACT_CLEAR) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                n_cnt[i] = '0;
            end
            n_latch = 1'b0;
            n_code  = FC_NONE;
        end else if (!r_latch) begin
            n_cnt  = w_tick;
            n_code = FC_NONE;
            // walk from lowest priority up so the first hit wins
            for (int i = NUM_CNT - 1; i >= 0; i--) begin
                if (w_hit[i]) begin
                    n_code = t_fault_code'(4'(i + 1));
                end
            end
            n_latch = |w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_latch <= 1'b0;
            r_code  <= FC_NONE;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_latch <= n_latch;
            r_code  <= n_code;
        end
    end

    assign o_result.fault_code    = n_code;
    assign o_result.fault_active  = (n_code != FC_NONE);
    assign o_result.fault_latched = n_latch;

endmodule

// ===== hdl/debounced_fault_latch_monitor_top.sv =====
// A sample word is accepted into the input register; its result word moves into the
// result register once that register is free to take it.
// Throughput: one word per cycle unless the output stalls; the counter update and
// priority pick sit in the single stage between the input and result registers.
// Reset (synchronous, active low): counters, latch and fault code clear,
// limits return to their defaults, both pipeline stages empty.
module debounced_fault_latch_monitor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dflm_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dflm_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dflm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dflm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dflm_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item w_result;
    t_cfg      w_cfg;
    logic      w_out_free, w_advance, w_in_acc;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;

    dflm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dflm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_advance),
        .i_item   (r_in_data),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold until the next word moves in
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data <= i_in_data;
        end
        if (w_advance) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/dflm_checker.sv =====
module dflm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dflm_pkg::t_out_item o_out_data
);
    import dflm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_active_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.fault_active == (o_out_data.fault_code != FC_NONE))
        else $error("fault_active disagrees with fault_code");

    // the latch is set exactly when a code is picked
    a_latch_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.fault_latched == o_out_data.fault_active)
        else $error("fault_latched disagrees with fault_active");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.fault_code <= FC_CONTACTOR)
        else $error("fault_code out of range");

endmodule

bind debounced_fault_latch_monitor_top dflm_checker u_dflm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
